FILE: rtl/core/dri_pkg.sv
package dri_pkg;

    localparam int MAX_WIDTH   = 16;
    localparam int VALUE_BITS  = 16;
    localparam int NUM_CFG     = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int WIDX_W      = 10;
    localparam int Q_W         = 16;
    localparam int OIDX_W      = 4;
    localparam int CNT_W       = 5;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER0_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER1_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER2_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER3_SIZE = 3'd4;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic signed [Q_W-1:0] ONE_Q88 = 16'sd256;

    typedef struct packed {
        logic                  func;
        logic [WIDX_W-1:0]     weight_index;
        logic signed [Q_W-1:0] weight_value;
        logic signed [Q_W-1:0] sample_value;
        logic                  last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] out_value;
        logic [OIDX_W-1:0]     out_index;
        logic                  last_output;
        logic                  size_error;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_item_t;

endpackage

FILE: rtl/core/dri_if.sv
interface dri_in_if;
    logic              valid;
    logic              ready;
    dri_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dri_out_if;
    logic               valid;
    logic               ready;
    dri_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dri_cfg_if;
    logic               valid;
    logic               ready;
    dri_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dri_ctrl.sv
module dri_ctrl #(
    parameter int MAX_LAYERS = 4,
    parameter int LW         = 3,
    parameter int NW         = 7,
    parameter int AW         = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    output logic                in_ready,
    input  dri_pkg::in_item_t   in_data,
    input  logic                size_match,
    input  logic                out_fire,
    input  logic                out_busy,
    input  logic [LW-1:0]       layers,
    input  logic [MAX_LAYERS-1:0][NW-1:0] sizes,
    input  logic                cfg_fire,
    output logic                clr_busy,
    output logic [AW-1:0]       clr_addr,
    output logic                cmd_mac_start,
    output logic                cmd_mac_en,
    output logic [AW-1:0]       cmd_waddr,
    output logic [NW-1:0]       cmd_k,
    output logic                cmd_mac_end,
    output logic [NW-1:0]       cmd_j,
    output logic                cmd_swap,
    output logic                cmd_emit,
    output logic                cmd_err,
    output logic [NW-1:0]       cmd_oj,
    output logic                cmd_olast
);
    localparam int DEPTH = (MAX_LAYERS - 1) * dri_pkg::MAX_WIDTH * dri_pkg::MAX_WIDTH;
    localparam int SIW   = $clog2(MAX_LAYERS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_ERR   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW:0]     clr_reg, clr_next;
    logic [LW-1:0]   l_reg, l_next;
    logic [NW-1:0]   j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]   woff_reg, woff_next;
    logic [1:0]      drain_reg, drain_next;
    logic [NW-1:0]   nin, nn, nout;

    always_comb
    begin
        nin  = sizes[SIW'(l_reg - LW'(1))];
        nn   = sizes[SIW'(l_reg)];
        nout = sizes[SIW'(layers - LW'(1))];
    end

    assign clr_busy = (state_reg == S_CLEAR);
    assign clr_addr = clr_reg[AW-1:0];
    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        l_next        = l_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        woff_next     = woff_reg;
        drain_next    = drain_reg;
        cmd_mac_start = 1'b0;
        cmd_mac_en    = 1'b0;
        cmd_mac_end   = 1'b0;
        cmd_swap      = 1'b0;
        cmd_emit      = 1'b0;
        cmd_err       = 1'b0;
        cmd_waddr     = AW'(woff_reg + AW'(k_reg));
        cmd_k         = k_reg;
        cmd_j         = j_reg;
        cmd_oj        = j_reg;
        cmd_olast     = (j_reg == nout - NW'(1));
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else if (in_fire && in_data.func == dri_pkg::FUNC_SAMPLE
                         && in_data.last_sample)
                begin
                    if (size_match)
                    begin
                        l_next     = LW'(1);
                        j_next     = '0;
                        k_next     = '0;
                        woff_next  = '0;
                        state_next = S_MAC;
                    end
                    else
                        state_next = S_ERR;
                end
            end
            S_MAC:
            begin
                if (l_reg >= layers)
                begin
                    j_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd_mac_en    = 1'b1;
                    cmd_mac_start = (k_reg == '0);
                    if (k_reg == nin - NW'(1))
                    begin
                        k_next     = '0;
                        woff_next  = AW'(woff_reg + AW'(nin));
                        drain_next = 2'd2;
                        state_next = S_DRAIN;
                    end
                    else
                        k_next = k_reg + NW'(1);
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd0)
                begin
                    cmd_mac_end = 1'b1;
                    if (j_reg == nn - NW'(1))
                    begin
                        j_next     = '0;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        j_next     = j_reg + NW'(1);
                        state_next = S_MAC;
                    end
                end
            end
            S_NEXT:
            begin
                cmd_swap   = 1'b1;
                l_next     = l_reg + LW'(1);
                state_next = S_MAC;
            end
            S_EMIT:
            begin
                if (!out_busy || out_fire)
                begin
                    cmd_emit = 1'b1;
                    j_next   = j_reg + NW'(1);
                    if (cmd_olast)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                cmd_err    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            l_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            woff_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            l_reg     <= l_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            woff_reg  <= woff_next;
            drain_reg <= drain_next;
        end
    end
endmodule

FILE: rtl/core/dri_datapath.sv
module dri_datapath #(
    parameter int MAX_LAYERS = 4,
    parameter int NW         = 7,
    parameter int AW         = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  dri_pkg::in_item_t   in_data,
    input  logic [AW:0]         used_total,
    input  logic [NW-1:0]       size0,
    input  logic                clr_busy,
    input  logic [AW-1:0]       clr_addr,
    input  logic                cmd_mac_start,
    input  logic                cmd_mac_en,
    input  logic [AW-1:0]       cmd_waddr,
    input  logic [NW-1:0]       cmd_k,
    input  logic                cmd_mac_end,
    input  logic [NW-1:0]       cmd_j,
    input  logic                cmd_swap,
    input  logic                cmd_emit,
    input  logic                cmd_err,
    input  logic [NW-1:0]       cmd_oj,
    input  logic                cmd_olast,
    output logic                size_match,
    input  logic                out_fire,
    output logic                out_valid,
    output dri_pkg::out_item_t  out_data
);
    localparam int MAX_WIDTH = dri_pkg::MAX_WIDTH;
    localparam int DEPTH = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
    localparam int IW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ACC_W = 2 * dri_pkg::Q_W + NW + 1;
    localparam logic signed [ACC_W-1:0] VMAX =
        ACC_W'((64'd1 << (dri_pkg::VALUE_BITS - 1)) - 64'd1);

    logic signed [dri_pkg::Q_W-1:0] wmem [DEPTH];
    logic signed [dri_pkg::Q_W-1:0] front [MAX_WIDTH];
    logic signed [dri_pkg::Q_W-1:0] back  [MAX_WIDTH];

    logic signed [dri_pkg::Q_W-1:0] w_rd_reg, a_rd_reg;
    logic                           v1_reg, st1_reg;
    logic signed [2*dri_pkg::Q_W-1:0] prod_reg;
    logic                           v2_reg, st2_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [dri_pkg::CNT_W-1:0]      cnt_reg;
    logic                           ovalid_reg;
    dri_pkg::out_item_t             odata_reg;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [dri_pkg::Q_W-1:0] relu;
    logic [dri_pkg::CNT_W-1:0]      cnt_inc;
    logic                           wr_en;

    assign wr_en = in_fire && in_data.func == dri_pkg::FUNC_WEIGHT
                   && {1'b0, in_data.weight_index} < used_total;

    always_ff @(posedge clk)
    begin
        if (clr_busy)
            wmem[clr_addr] <= dri_pkg::ONE_Q88;
        else if (wr_en)
            wmem[in_data.weight_index[AW-1:0]] <= in_data.weight_value;
        w_rd_reg <= wmem[cmd_waddr];
    end

    always_ff @(posedge clk)
    begin
        a_rd_reg <= front[cmd_k[IW-1:0]];
        prod_reg <= w_rd_reg * a_rd_reg;
        if (in_fire && in_data.func == dri_pkg::FUNC_SAMPLE && cnt_reg < dri_pkg::CNT_W'(MAX_WIDTH))
            front[cnt_reg[IW-1:0]] <= in_data.sample_value;
        else if (cmd_swap)
            for (int i = 0; i < MAX_WIDTH; i++)
                front[i] <= back[i];
        if (cmd_mac_end)
            back[cmd_j[IW-1:0]] <= relu;
        if (v2_reg)
            acc_reg <= (st2_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_comb
    begin
        shifted = acc_reg >>> 8;
        if (acc_reg < 0)
            relu = '0;
        else if (shifted > VMAX)
            relu = dri_pkg::Q_W'(VMAX);
        else
            relu = dri_pkg::Q_W'(shifted);
        cnt_inc = (cnt_reg == 5'd31) ? cnt_reg : cnt_reg + 5'd1;
    end

    assign size_match = (NW'(cnt_inc) == size0);
    assign out_valid  = ovalid_reg;
    assign out_data   = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            st1_reg    <= 1'b0;
            v2_reg     <= 1'b0;
            st2_reg    <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            v1_reg  <= cmd_mac_en;
            st1_reg <= cmd_mac_start;
            v2_reg  <= v1_reg;
            st2_reg <= st1_reg;
            if (in_fire && in_data.func == dri_pkg::FUNC_SAMPLE)
            begin
                if (in_data.last_sample)
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_inc;
            end
            if (cmd_err)
            begin
                ovalid_reg            <= 1'b1;
                odata_reg.out_value   <= '0;
                odata_reg.out_index   <= '0;
                odata_reg.last_output <= 1'b1;
                odata_reg.size_error  <= 1'b1;
            end
            else if (cmd_emit)
            begin
                ovalid_reg            <= 1'b1;
                odata_reg.out_value   <= front[cmd_oj[IW-1:0]];
                odata_reg.out_index   <= dri_pkg::OIDX_W'(cmd_oj);
                odata_reg.last_output <= cmd_olast;
                odata_reg.size_error  <= 1'b0;
            end
            else if (out_fire)
                ovalid_reg <= 1'b0;
        end
    end
endmodule

FILE: rtl/core/dense_relu_network_inference.sv
// dense relu network inference
// channels: in (func, weight_index, weight_value, sample_value, last_sample),
// out (out_value, out_index, last_output, size_error), cfg (index, data).
// func 0 writes one weight; func 1 stores one input value.
// on the value marked last, if the input count matches the first layer size,
// the network runs on the single multiply-accumulate unit fed by the weight
// memory read port, neuron by neuron and layer by layer; the results then
// leave one per cycle while the receiver takes them.
// a size mismatch gives a single error result, raised from the error state.
// reset and every write to a known register refill the 768 weights with 1.0,
// one per cycle, during which no input is taken; config writes are taken only
// when idle, and input is refused while a config write is offered.
// when the receiver stalls the result register holds and the block waits
// before the next result; input is refused while any result is pending.
module dense_relu_network_inference #(
    parameter int MAX_LAYERS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    dri_in_if.sink    in_ch,
    dri_out_if.source out_ch,
    dri_cfg_if.sink   cfg
);
    localparam int MAX_WIDTH = dri_pkg::MAX_WIDTH;
    localparam int NW = $clog2(MAX_WIDTH + 1) + 1;
    localparam int LW = $clog2(MAX_LAYERS + 1);
    localparam int AW = $clog2((MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH);

    logic [dri_pkg::CFG_DATA_W-1:0] cfg_reg [dri_pkg::NUM_CFG];
    logic [LW-1:0]                  layers;
    logic [MAX_LAYERS-1:0][NW-1:0]  sizes;
    logic [AW:0]                    used_total;
    logic                           in_fire, out_fire, cfg_fire, out_busy;
    logic                           cfg_write, size_match;
    logic                           clr_busy;
    logic [AW-1:0]                  clr_addr, cmd_waddr;
    logic                           cmd_mac_start, cmd_mac_en, cmd_mac_end, cmd_swap;
    logic                           cmd_emit, cmd_err, cmd_olast, in_ready_c;
    logic [NW-1:0]                  cmd_k, cmd_j, cmd_oj;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg_write = cfg_fire && cfg.data.index < dri_pkg::CFG_IDX_W'(dri_pkg::NUM_CFG);
    assign out_busy = out_ch.valid;
    assign in_ch.ready = in_ready_c && !cfg.valid;
    assign cfg.ready   = in_ready_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[dri_pkg::REG_LAYER_COUNT] <= 5'd2;
            for (int i = 1; i < dri_pkg::NUM_CFG; i++)
                cfg_reg[i] <= 5'd1;
        end
        else if (cfg_write)
        begin
            if (cfg.data.index == dri_pkg::REG_LAYER_COUNT)
                cfg_reg[dri_pkg::REG_LAYER_COUNT] <= {2'b0, cfg.data.data[2:0]};
            else
                cfg_reg[cfg.data.index] <= cfg.data.data;
        end
    end

    always_comb
    begin
        if (cfg_reg[dri_pkg::REG_LAYER_COUNT] == 5'd0)
            layers = LW'(1);
        else if (cfg_reg[dri_pkg::REG_LAYER_COUNT] > 5'(MAX_LAYERS))
            layers = LW'(MAX_LAYERS);
        else
            layers = LW'(cfg_reg[dri_pkg::REG_LAYER_COUNT]);
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            if (i + 1 >= dri_pkg::NUM_CFG || cfg_reg[(i + 1) % dri_pkg::NUM_CFG] == 5'd0)
                sizes[i] = NW'(1);
            else if (NW'(cfg_reg[(i + 1) % dri_pkg::NUM_CFG]) > NW'(MAX_WIDTH))
                sizes[i] = NW'(MAX_WIDTH);
            else
                sizes[i] = NW'(cfg_reg[(i + 1) % dri_pkg::NUM_CFG]);
        end
        used_total = '0;
        for (int i = 1; i < MAX_LAYERS; i++)
            if (LW'(i) < layers)
                used_total = used_total + (AW+1)'(sizes[i]) * (AW+1)'(sizes[i-1]);
    end

    dri_ctrl #(.MAX_LAYERS(MAX_LAYERS), .LW(LW), .NW(NW), .AW(AW))
    u_ctrl (
        .clk, .rst_n,
        .in_fire, .in_ready(in_ready_c), .in_data(in_ch.data), .size_match,
        .out_fire, .out_busy, .layers, .sizes, .cfg_fire(cfg_write),
        .clr_busy, .clr_addr, .cmd_mac_start, .cmd_mac_en, .cmd_waddr, .cmd_k,
        .cmd_mac_end, .cmd_j, .cmd_swap, .cmd_emit, .cmd_err, .cmd_oj, .cmd_olast
    );

    dri_datapath #(.MAX_LAYERS(MAX_LAYERS), .NW(NW), .AW(AW))
    u_dp (
        .clk, .rst_n, .in_fire, .in_data(in_ch.data), .used_total, .size0(sizes[0]),
        .clr_busy, .clr_addr, .cmd_mac_start, .cmd_mac_en, .cmd_waddr, .cmd_k,
        .cmd_mac_end, .cmd_j, .cmd_swap, .cmd_emit, .cmd_err, .cmd_oj, .cmd_olast,
        .size_match, .out_fire, .out_valid(out_ch.valid), .out_data(out_ch.data)
    );
endmodule

FILE: rtl/core/dri_checker.sv
module dri_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dri_pkg::out_item_t out_data,
    input logic               cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out stalled payload changed");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.size_error |-> out_data.last_output && out_data.out_value == '0)
        else $error("error result malformed");
    a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.size_error |-> out_data.out_index == '0)
        else $error("error result index nonzero");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready && !cfg_ready)
        else $error("input taken while result pending");
    a_fire_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result right after input transfer");
endmodule

bind dense_relu_network_inference dri_checker u_chk (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_ready(cfg.ready)
);
